// ===== rtl/assert_macros.svh =====
// Assertion macros used by the rasterizer pixel engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequence holds in the cycle after its cause.
`define ASSERT_NEXT(lbl, cause, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/trdb_pkg.sv =====
// Types, constants and helper functions of the triangle rasterizer.
`default_nettype none
package trdb_pkg;
    localparam int FRAME_WIDTH = 256;
    localparam int FRAME_HEIGHT = 256;
    localparam int SUBPIXEL_BITS = 4;
    localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(PIXEL_COUNT);
    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = $clog2(FRAME_HEIGHT);
    localparam int PCOORD_W = 17;
    localparam int DIFF_W = 18;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int EDGE_W = 40;
    localparam int WGT_W = 36;
    localparam int Z_W = 16;
    localparam int NUM_W = Z_W + WGT_W + 2;
    localparam int COLOR_W = 24;
    localparam int ALPHA_W = 9;
    localparam int COUNT_W = 17;
    localparam int WORD_W = Z_W + COLOR_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [Z_W-1:0] Z_FAR = '1;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'd255;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd77;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] vertex0_x;
        logic signed [15:0] vertex0_y;
        logic [15:0]        vertex0_z;
        logic signed [15:0] vertex1_x;
        logic signed [15:0] vertex1_y;
        logic [15:0]        vertex1_z;
        logic signed [15:0] vertex2_x;
        logic signed [15:0] vertex2_y;
        logic [15:0]        vertex2_z;
        logic [23:0]        pixel_color;
    } in_item_t;

    typedef struct packed {
        logic [23:0] read_color;
        logic [15:0] read_depth;
        logic [16:0] pixels_written;
        logic        out_of_frame;
    } out_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ALPHA_W-1:0] alpha;
    } blend_cfg_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic                      skip;
        logic                      out_of_frame;
        logic [COL_W-1:0]          lx;
        logic [COL_W-1:0]          hx;
        logic [ROW_W-1:0]          ly;
        logic [ROW_W-1:0]          hy;
        logic [WGT_W-1:0]          area;
        logic signed [EDGE_W-1:0]  ux;
        logic signed [EDGE_W-1:0]  uy;
        logic signed [EDGE_W-1:0]  ux_dx;
        logic signed [EDGE_W-1:0]  ux_dy;
        logic signed [EDGE_W-1:0]  uy_dx;
        logic signed [EDGE_W-1:0]  uy_dy;
        logic [Z_W-1:0]            z0;
        logic [Z_W-1:0]            z1;
        logic [Z_W-1:0]            z2;
        logic [ADDR_W-1:0]         addr;
        logic [COLOR_W-1:0]        color;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
        return ADDR_W'(col) + ADDR_W'(row) * ADDR_W'(FRAME_WIDTH);
    endfunction

    function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] fresh,
                                                 input logic [COLOR_W-1:0] old,
                                                 input logic [ALPHA_W-1:0] a);
        logic [17:0] a18;
        logic [17:0] ia18;
        logic [17:0] acc;
        logic [COLOR_W-1:0] res;
        a18 = 18'(a);
        ia18 = 18'(ALPHA_FULL - a);
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 18'(fresh[ch*8 +: 8]) * a18 + 18'(old[ch*8 +: 8]) * ia18;
            res[ch*8 +: 8] = acc[15:8];
        end
        return res;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/trdb_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module trdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/trdb_front.sv =====
// Front end: accepts items, computes triangle setup and pixel addresses.
`default_nettype none
module trdb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  trdb_pkg::in_item_t in_data,
    input  logic              clear_done,
    output logic              push,
    output trdb_pkg::cmd_t    push_data,
    input  logic              full
);
    import trdb_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_SETUP = 5'b00010,
        F_MUL   = 5'b00100,
        F_SIGN  = 5'b01000,
        F_PUSH  = 5'b10000
    } fstate_t;

    localparam logic signed [PCOORD_W-1:0] MAX_COL = PCOORD_W'(FRAME_WIDTH - 1);
    localparam logic signed [PCOORD_W-1:0] MAX_ROW = PCOORD_W'(FRAME_HEIGHT - 1);
    localparam int STEP_SH = SUBPIXEL_BITS + 1;

    fstate_t state_reg, state_next;
    in_item_t item_reg;
    cmd_t cmd_reg;
    logic signed [DIFF_W-1:0] ex1_reg, ey1_reg, ex2_reg, ey2_reg, dx0_reg, dy0_reg;
    logic empty_reg;
    logic [2:0] step_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [EDGE_W-1:0] area_reg, ux_reg, uy_reg;

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic signed [PCOORD_W-1:0] plx, phx, ply, phy, clx, chx, cly, chy, ppx, ppy;
    logic signed [DIFF_W-1:0] ax, ay, cenx, ceny;
    logic signed [DIFF_W-1:0] ma, mb;
    logic signed [EDGE_W-1:0] e_ux_dx, e_ux_dy, e_uy_dx, e_uy_dy;
    logic neg;

    always_comb
    begin
        plx = PCOORD_W'(min3(item_reg.vertex0_x, item_reg.vertex1_x, item_reg.vertex2_x)
                        >>> SUBPIXEL_BITS);
        phx = PCOORD_W'(max3(item_reg.vertex0_x, item_reg.vertex1_x, item_reg.vertex2_x)
                        >>> SUBPIXEL_BITS);
        ply = PCOORD_W'(min3(item_reg.vertex0_y, item_reg.vertex1_y, item_reg.vertex2_y)
                        >>> SUBPIXEL_BITS);
        phy = PCOORD_W'(max3(item_reg.vertex0_y, item_reg.vertex1_y, item_reg.vertex2_y)
                        >>> SUBPIXEL_BITS);
        clx = (plx < 0) ? '0 : plx;
        cly = (ply < 0) ? '0 : ply;
        chx = (phx > MAX_COL) ? MAX_COL : phx;
        chy = (phy > MAX_ROW) ? MAX_ROW : phy;
        ppx = PCOORD_W'(item_reg.vertex0_x >>> SUBPIXEL_BITS);
        ppy = PCOORD_W'(item_reg.vertex0_y >>> SUBPIXEL_BITS);
        ax = DIFF_W'(item_reg.vertex0_x) <<< 1;
        ay = DIFF_W'(item_reg.vertex0_y) <<< 1;
        cenx = $signed(DIFF_W'({clx[COL_W-1:0], 1'b1})) <<< SUBPIXEL_BITS;
        ceny = $signed(DIFF_W'({cly[ROW_W-1:0], 1'b1})) <<< SUBPIXEL_BITS;
    end

    always_comb
    begin
        case (step_reg)
            3'd0:    begin ma = ex2_reg; mb = ey1_reg; end
            3'd1:    begin ma = ex1_reg; mb = ey2_reg; end
            3'd2:    begin ma = ex1_reg; mb = dy0_reg; end
            3'd3:    begin ma = dx0_reg; mb = ey1_reg; end
            3'd4:    begin ma = dx0_reg; mb = ey2_reg; end
            default: begin ma = ex2_reg; mb = dy0_reg; end
        endcase
    end

    always_comb
    begin
        neg = area_reg < 0;
        e_ux_dx = EDGE_W'(ey1_reg) <<< STEP_SH;
        e_ux_dy = -(EDGE_W'(ex1_reg) <<< STEP_SH);
        e_uy_dx = -(EDGE_W'(ey2_reg) <<< STEP_SH);
        e_uy_dy = EDGE_W'(ex2_reg) <<< STEP_SH;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (in_valid && in_ready) state_next = F_SETUP;
            F_SETUP: state_next = (item_reg.operation == OP_DRAW) ? F_MUL : F_PUSH;
            F_MUL:   if (step_reg == 3'd6) state_next = F_SIGN;
            F_SIGN:  state_next = F_PUSH;
            F_PUSH:  if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (state_reg == F_SETUP)
        begin
            ex1_reg <= (DIFF_W'(item_reg.vertex1_x) - DIFF_W'(item_reg.vertex0_x)) <<< 1;
            ey1_reg <= (DIFF_W'(item_reg.vertex1_y) - DIFF_W'(item_reg.vertex0_y)) <<< 1;
            ex2_reg <= (DIFF_W'(item_reg.vertex2_x) - DIFF_W'(item_reg.vertex0_x)) <<< 1;
            ey2_reg <= (DIFF_W'(item_reg.vertex2_y) - DIFF_W'(item_reg.vertex0_y)) <<< 1;
            dx0_reg <= ax - cenx;
            dy0_reg <= ay - ceny;
            empty_reg <= (clx > chx) || (cly > chy);
            step_reg <= '0;
            area_reg <= '0;
            ux_reg <= '0;
            uy_reg <= '0;
            cmd_reg.operation <= item_reg.operation;
            cmd_reg.lx <= clx[COL_W-1:0];
            cmd_reg.hx <= chx[COL_W-1:0];
            cmd_reg.ly <= cly[ROW_W-1:0];
            cmd_reg.hy <= chy[ROW_W-1:0];
            cmd_reg.z0 <= item_reg.vertex0_z;
            cmd_reg.z1 <= item_reg.vertex1_z;
            cmd_reg.z2 <= item_reg.vertex2_z;
            cmd_reg.color <= item_reg.pixel_color;
            cmd_reg.out_of_frame <= (ppx < 0) || (ppx > MAX_COL)
                                    || (ppy < 0) || (ppy > MAX_ROW);
            cmd_reg.addr <= pix_addr(ppx[COL_W-1:0], ppy[ROW_W-1:0]);
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= ma * mb;
            step_reg <= step_reg + 3'd1;
            case (step_reg)
                3'd1:    area_reg <= area_reg + EDGE_W'(prod_reg);
                3'd2:    area_reg <= area_reg - EDGE_W'(prod_reg);
                3'd3:    ux_reg <= ux_reg + EDGE_W'(prod_reg);
                3'd4:    ux_reg <= ux_reg - EDGE_W'(prod_reg);
                3'd5:    uy_reg <= uy_reg + EDGE_W'(prod_reg);
                3'd6:    uy_reg <= uy_reg - EDGE_W'(prod_reg);
                default: ;
            endcase
        end
        if (state_reg == F_SIGN)
        begin
            cmd_reg.skip <= empty_reg || (area_reg == '0);
            cmd_reg.area <= WGT_W'(neg ? -area_reg : area_reg);
            cmd_reg.ux <= neg ? -ux_reg : ux_reg;
            cmd_reg.uy <= neg ? -uy_reg : uy_reg;
            cmd_reg.ux_dx <= neg ? -e_ux_dx : e_ux_dx;
            cmd_reg.ux_dy <= neg ? -e_ux_dy : e_ux_dy;
            cmd_reg.uy_dx <= neg ? -e_uy_dx : e_uy_dx;
            cmd_reg.uy_dy <= neg ? -e_uy_dy : e_uy_dy;
        end
    end

    assign in_ready = (state_reg == F_IDLE) && clear_done;
    assign push = (state_reg == F_PUSH) && !full;
    assign push_data = cmd_reg;
endmodule
`default_nettype wire

// ===== rtl/trdb_queue.sv =====
// Short command queue between the front end and the pixel engine.
`default_nettype none
module trdb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  trdb_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output trdb_pkg::cmd_t pop_data
);
    import trdb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [PTR_W:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    assign full = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign pop_data = entry_reg[rptr_reg];
endmodule
`default_nettype wire

// ===== rtl/trdb_back.sv =====
// Pixel engine: buffer clearing, box walk, depth test, blending and results.
`default_nettype none
`include "assert_macros.svh"
module trdb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  trdb_pkg::cmd_t       q_data,
    output logic                 q_pop,
    input  trdb_pkg::blend_cfg_t cfg,
    output logic                 clear_done,
    output logic                 out_valid,
    input  logic                 out_ready,
    output trdb_pkg::out_item_t  out_data
);
    import trdb_pkg::*;

    typedef enum logic [8:0] {
        B_CLEAR  = 9'b000000001,
        B_IDLE   = 9'b000000010,
        B_TEST   = 9'b000000100,
        B_MUL    = 9'b000001000,
        B_DIV    = 9'b000010000,
        B_UPD    = 9'b000100000,
        B_STEP   = 9'b001000000,
        B_READ   = 9'b010000000,
        B_RESULT = 9'b100000000
    } bstate_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXEL_COUNT - 1);

    bstate_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg;
    logic clear_done_reg;
    cmd_t cmd_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic signed [EDGE_W-1:0] ux_reg, uy_reg, uxc_reg, uyc_reg;
    logic [WGT_W-1:0] w0_reg;
    logic [1:0] mstep_reg;
    logic [NUM_W-1:0] prod_reg, num_reg, rem_reg, den_reg;
    logic [Z_W-1:0] quo_reg;
    logic [3:0] dcnt_reg;
    logic [COUNT_W-1:0] count_reg;
    out_item_t res_reg, out_reg;
    logic out_valid_reg;

    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic signed [EDGE_W-1:0] w0s;
    logic covered, pass, out_load;
    logic in_box, rem_small;
    logic [Z_W-1:0] mz;
    logic [WGT_W-1:0] mw;
    logic [Z_W+WGT_W-1:0] mprod;
    logic [ALPHA_W-1:0] alpha;

    always_comb
    begin
        w0s = $signed(EDGE_W'(cmd_reg.area)) - ux_reg - uy_reg;
        covered = !ux_reg[EDGE_W-1] && !uy_reg[EDGE_W-1] && !w0s[EDGE_W-1];
        case (mstep_reg)
            2'd0:    begin mz = cmd_reg.z0; mw = w0_reg; end
            2'd1:    begin mz = cmd_reg.z1; mw = uy_reg[WGT_W-1:0]; end
            default: begin mz = cmd_reg.z2; mw = ux_reg[WGT_W-1:0]; end
        endcase
        mprod = mz * mw;
        pass = quo_reg < ram_rdata[WORD_W-1:COLOR_W];
        alpha = (cfg.alpha > ALPHA_FULL) ? ALPHA_FULL : cfg.alpha;
        out_load = (state_reg == B_RESULT) && (!out_valid_reg || out_ready);
        in_box = (col_reg <= cmd_reg.hx) && (row_reg <= cmd_reg.hy);
        rem_small = rem_reg < NUM_W'(cmd_reg.area);
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = cmd_reg.addr;
        ram_wdata = {cmd_reg.z0, cmd_reg.color};
        ram_re = 1'b0;
        ram_raddr = pix_addr(col_reg, row_reg);
        q_pop = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {Z_FAR, COLOR_W'(0)};
            end
            B_IDLE:
            begin
                q_pop = q_valid;
                ram_waddr = q_data.addr;
                ram_wdata = {q_data.z0, q_data.color};
                ram_raddr = q_data.addr;
                ram_we = q_valid && (q_data.operation == OP_WRITE) && !q_data.out_of_frame;
                ram_re = q_valid && (q_data.operation == OP_READ) && !q_data.out_of_frame;
            end
            B_TEST:
            begin
                ram_re = covered;
            end
            B_UPD:
            begin
                ram_we = pass;
                ram_waddr = pix_addr(col_reg, row_reg);
                ram_wdata = {quo_reg, blend(cfg.color, ram_rdata[COLOR_W-1:0], alpha)};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:  if (clr_reg == LAST_ADDR) state_next = B_IDLE;
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.operation == OP_DRAW && !q_data.skip)
                    begin
                        state_next = B_TEST;
                    end
                    else if (q_data.operation == OP_READ && !q_data.out_of_frame)
                    begin
                        state_next = B_READ;
                    end
                    else
                    begin
                        state_next = B_RESULT;
                    end
                end
            end
            B_TEST:   state_next = covered ? B_MUL : B_STEP;
            B_MUL:    if (mstep_reg == 2'd3) state_next = B_DIV;
            B_DIV:    if (dcnt_reg == 4'd15) state_next = B_UPD;
            B_UPD:    state_next = B_STEP;
            B_STEP:
            begin
                if (row_reg == cmd_reg.hy && col_reg == cmd_reg.hx)
                begin
                    state_next = B_RESULT;
                end
                else
                begin
                    state_next = B_TEST;
                end
            end
            B_READ:   state_next = B_RESULT;
            B_RESULT: if (out_load) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg <= '0;
            clear_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    clear_done_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_reg <= q_data;
                    col_reg <= q_data.lx;
                    row_reg <= q_data.ly;
                    ux_reg <= q_data.ux;
                    uy_reg <= q_data.uy;
                    uxc_reg <= q_data.ux;
                    uyc_reg <= q_data.uy;
                    count_reg <= '0;
                    res_reg.read_color <= '0;
                    res_reg.read_depth <= '0;
                    res_reg.pixels_written <= '0;
                    res_reg.out_of_frame <= (q_data.operation == OP_WRITE
                                             || q_data.operation == OP_READ)
                                            && q_data.out_of_frame;
                end
            end
            B_TEST:
            begin
                w0_reg <= w0s[WGT_W-1:0];
                mstep_reg <= '0;
            end
            B_MUL:
            begin
                prod_reg <= NUM_W'(mprod);
                mstep_reg <= mstep_reg + 2'd1;
                if (mstep_reg == 2'd1)
                begin
                    num_reg <= prod_reg;
                end
                else if (mstep_reg == 2'd2)
                begin
                    num_reg <= num_reg + prod_reg;
                end
                else if (mstep_reg == 2'd3)
                begin
                    rem_reg <= num_reg + prod_reg;
                    den_reg <= NUM_W'(cmd_reg.area) << (Z_W - 1);
                    quo_reg <= '0;
                    dcnt_reg <= '0;
                end
            end
            B_DIV:
            begin
                if (rem_reg >= den_reg)
                begin
                    rem_reg <= rem_reg - den_reg;
                    quo_reg <= {quo_reg[Z_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[Z_W-2:0], 1'b0};
                end
                den_reg <= den_reg >> 1;
                dcnt_reg <= dcnt_reg + 4'd1;
            end
            B_UPD:
            begin
                if (pass && count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            B_STEP:
            begin
                if (row_reg != cmd_reg.hy)
                begin
                    row_reg <= row_reg + 1'b1;
                    ux_reg <= ux_reg + cmd_reg.ux_dy;
                    uy_reg <= uy_reg + cmd_reg.uy_dy;
                end
                else if (col_reg != cmd_reg.hx)
                begin
                    col_reg <= col_reg + 1'b1;
                    row_reg <= cmd_reg.ly;
                    uxc_reg <= uxc_reg + cmd_reg.ux_dx;
                    uyc_reg <= uyc_reg + cmd_reg.uy_dx;
                    ux_reg <= uxc_reg + cmd_reg.ux_dx;
                    uy_reg <= uyc_reg + cmd_reg.uy_dx;
                end
                else
                begin
                    res_reg.pixels_written <= count_reg;
                end
            end
            B_READ:
            begin
                res_reg.read_color <= ram_rdata[COLOR_W-1:0];
                res_reg.read_depth <= ram_rdata[WORD_W-1:COLOR_W];
            end
            default: ;
        endcase
    end

    trdb_ram #(
        .WIDTH(WORD_W),
        .DEPTH(PIXEL_COUNT)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign clear_done = clear_done_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `ASSERT_CLK(a_pop_after_clear, q_pop |-> clear_done_reg, "command popped during clear")
    `ASSERT_CLK(a_walk_in_box, (state_reg == B_TEST) |-> in_box, "walk left the box")
    `ASSERT_CLK(a_div_rem, (state_reg == B_UPD) |-> rem_small, "depth quotient overflow")
    `ASSERT_NEXT(a_result_shown, out_load, out_valid_reg, "result not presented")
endmodule
`default_nettype wire

// ===== rtl/triangle_raster_depth_blend.sv =====
// Top level of the triangle rasterizer with depth test and alpha blend.
// Writes pass front-end setup, the command queue and the result stage; in-frame reads
// also pass the RAM read state. A draw is set up in the front end, then the pixel engine
// walks the clamped bounding box; each covered pixel runs multiply steps and the 16-step
// divider. The pixel engine takes one item at a time; the front end can set up the next.
// After reset a clearing pass initializes the buffers; no beat is taken then.
`default_nettype none
module triangle_raster_depth_blend (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  trdb_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output trdb_pkg::out_item_t                   out_data,
    input  logic                                  cfg_write,
    input  logic [trdb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [trdb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import trdb_pkg::*;

    blend_cfg_t cfg_reg;
    logic push, full, pop, q_valid, clear_done;
    cmd_t push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color <= COLOR_RESET;
            cfg_reg.alpha <= ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BLEND_COLOR: cfg_reg.color <= cfg_data[COLOR_W-1:0];
                REG_BLEND_ALPHA: cfg_reg.alpha <= cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    trdb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .clear_done(clear_done),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    trdb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .valid    (q_valid),
        .pop_data (pop_data)
    );

    trdb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .cfg       (cfg_reg),
        .clear_done(clear_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire
